>>> rtl/urc_pkg.sv
// shared types, codes and constant tables for the ultrasonic ranging controller
package urc_pkg;

  // command codes carried in the input tuser
  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_DISABLED = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_RSVD     = 2'd3
  } status_t;

  // configuration register indexes
  localparam logic [1:0] CFG_RANGE_MODE   = 2'd0;
  localparam logic [1:0] CFG_TRIGGER_RATE = 2'd1;
  localparam logic [1:0] CFG_BLOCK_ENABLE = 2'd2;

  localparam int DIST_W = 16;
  localparam int RATE_W = 5;
  localparam int MS_W   = 10;

  // request from the ranging logic to the distance fifo for one tick
  typedef struct packed {
    logic              valid;
    logic              push;
    logic              clear;
    logic              read;
    logic [DIST_W-1:0] push_data;
  } fifo_req_t;

  // fifo state after the request is applied
  typedef struct packed {
    logic       empty;
    logic [2:0] fill_count;
  } fifo_stat_t;

  // trigger period in ms for a rate in hertz, rate clamped to 1..16
  function automatic logic [MS_W-1:0] ms_per_period(input logic [RATE_W-1:0] rate);
    logic [MS_W-1:0] ms;
    case (rate)
      5'd0, 5'd1: ms = 10'd1000;
      5'd2:       ms = 10'd500;
      5'd3:       ms = 10'd333;
      5'd4:       ms = 10'd250;
      5'd5:       ms = 10'd200;
      5'd6:       ms = 10'd166;
      5'd7:       ms = 10'd142;
      5'd8:       ms = 10'd125;
      5'd9:       ms = 10'd111;
      5'd10:      ms = 10'd100;
      5'd11:      ms = 10'd90;
      5'd12:      ms = 10'd83;
      5'd13:      ms = 10'd76;
      5'd14:      ms = 10'd71;
      5'd15:      ms = 10'd66;
      default:    ms = 10'd62;
    endcase
    return ms;
  endfunction

endpackage

>>> rtl/ultrasonic_ranging_controller_top.sv
// ultrasonic ranging controller: trigger generation, echo timing and distance fifo
//
// Each input transaction on the s_ group is one timestamp tick: s_tuser holds the
// command (tick, write or read), s_tdata the sampled echo level and the write
// argument. For every input transaction exactly one result transaction leaves
// on the m_ group: trigger level, popped distance, status, fill count and
// whether continuous ranging runs; m_tuser flags a valid popped distance.
// The cfg port writes range mode, trigger rate and enable at any edge with
// cfg_we high; write it only while no tick is in flight.
// From input to result a tick passes the input register, then the tick logic into
// the result register. One tick is taken every cycle while the receiver does not
// stall; the tick logic and the fifo update take effect together when a tick advances.
// The echo width is turned into centimetres by a running remainder/quotient
// counter, so no divider is needed. When the receiver stalls, the result
// register holds and one more tick can still wait in the input register, after
// which s_tready drops. Synchronous reset empties both registers, stops
// ranging, clears the fifo count and returns the config registers to one-shot
// mode, 16 Hz and enabled.
module ultrasonic_ranging_controller_top #(
  parameter int FIFO_DEPTH   = 5,
  parameter int TICKS_PER_US = 400,
  parameter int US_PER_CM    = 58,
  parameter int TRIGGER_US   = 10
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  // input ticks
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // echo_level, write_value, zero fill
  input  logic [1:0]  s_tuser,   // cmd
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // trigger_level, distance_cm, status, fill_count,
                                 // ranging_active, zero fill
  output logic [0:0]  m_tuser    // read_valid
);
  import urc_pkg::*;

  localparam int PULSE_TICKS  = TRIGGER_US * TICKS_PER_US;
  localparam int PULSE_W      = $clog2(PULSE_TICKS + 1);
  localparam int TICKS_PER_CM = US_PER_CM * TICKS_PER_US;
  localparam int REM_W        = (TICKS_PER_CM > 1) ? $clog2(TICKS_PER_CM) : 1;
  localparam int TICKS_PER_MS = 1000 * TICKS_PER_US;
  localparam int PERIOD_W     = $clog2(1000 * TICKS_PER_MS);
  localparam logic [REM_W-1:0]    REM_LAST    = REM_W'(TICKS_PER_CM - 1);
  localparam logic [PULSE_W-1:0]  PULSE_LOAD  = PULSE_W'(PULSE_TICKS - 1);
  localparam logic [PERIOD_W-1:0] PERIOD_INIT = PERIOD_W'(62 * TICKS_PER_MS - 1);

  // configuration registers
  logic              range_mode;
  logic [RATE_W-1:0] trigger_rate_hz;
  logic              block_enable;
  logic [PERIOD_W-1:0] period_reload;

  // input register
  logic s1_valid;
  cmd_t s1_cmd;
  logic s1_echo;
  logic s1_wval;

  // ranging state
  logic                echo_prev;
  logic [31:0]         width_count, width_count_next;
  logic [REM_W-1:0]    width_rem, width_rem_next;
  logic [DIST_W-1:0]   width_cm, width_cm_next;
  logic [PULSE_W-1:0]  pulse_count, pulse_count_next;
  logic [PERIOD_W-1:0] period_count, period_count_next;
  logic                running, running_next;

  // result register
  logic    r_trig;
  logic    r_valid;
  status_t r_status;
  logic [2:0] r_fill;
  logic    r_active;

  // tick logic signals
  logic s2_free, advance;
  logic push, step_en;
  logic [REM_W-1:0]  rem_base;
  logic [DIST_W-1:0] cm_base;
  logic is_write, is_read, cmd_any, oneshot, start;
  logic run_cmd;
  logic [PERIOD_W-1:0] period_cmd;
  logic fire, pulse_set, trig;
  logic read_valid;
  status_t status;

  fifo_req_t  fifo_req;
  fifo_stat_t fifo_stat;
  logic [DIST_W-1:0] fifo_rd;

  // handshake
  assign s2_free  = !m_tvalid || m_tready;
  assign advance  = s1_valid && s2_free;
  assign s_tready = !s1_valid || s2_free;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      range_mode      <= 1'b0;
      trigger_rate_hz <= RATE_W'(16);
      block_enable    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RANGE_MODE:   range_mode      <= cfg_data[0];
        CFG_TRIGGER_RATE: trigger_rate_hz <= cfg_data;
        CFG_BLOCK_ENABLE: block_enable    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // period reload in ticks, recomputed from the rate register
  always_ff @(posedge clk) begin
    if (rst) begin
      period_reload <= PERIOD_INIT;
    end else begin
      period_reload <= PERIOD_W'({22'd0, ms_per_period(trigger_rate_hz)} *
                                 32'(TICKS_PER_MS) - 32'd1);
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_cmd  <= cmd_t'(s_tuser);
      s1_echo <= s_tdata[0];
      s1_wval <= s_tdata[1];
    end
  end

  // echo timing: width in ticks kept as centimetres plus remainder
  always_comb begin
    push     = !s1_echo && echo_prev;
    rem_base = echo_prev ? width_rem : '0;
    cm_base  = echo_prev ? width_cm : '0;
    step_en  = s1_echo && (!echo_prev || (width_count != '1));
    if (!s1_echo) begin
      width_count_next = width_count;
    end else if (!echo_prev) begin
      width_count_next = 32'd1;
    end else if (width_count != '1) begin
      width_count_next = width_count + 32'd1;
    end else begin
      width_count_next = width_count;
    end
    width_rem_next = width_rem;
    width_cm_next  = width_cm;
    if (step_en) begin
      if (rem_base == REM_LAST) begin
        width_rem_next = '0;
        width_cm_next  = (cm_base == '1) ? cm_base : DIST_W'(cm_base + 1'b1);
      end else begin
        width_rem_next = REM_W'(rem_base + 1'b1);
        width_cm_next  = cm_base;
      end
    end
  end

  // command decode, continuous triggering and the trigger pulse
  always_comb begin
    is_write   = (s1_cmd == CMD_WRITE);
    is_read    = (s1_cmd == CMD_READ);
    cmd_any    = is_write || is_read;
    oneshot    = !range_mode;
    start      = block_enable && is_write && range_mode && s1_wval;
    run_cmd    = (block_enable && is_write && range_mode) ? s1_wval
                                                          : (range_mode && running);
    period_cmd = start ? '0 : period_count;
    fire       = run_cmd && (period_cmd == '0);
    if (!run_cmd) begin
      period_count_next = period_cmd;
    end else if (fire) begin
      period_count_next = period_reload;
    end else begin
      period_count_next = PERIOD_W'(period_cmd - 1'b1);
    end
    running_next = run_cmd;
    pulse_set    = (block_enable && oneshot && cmd_any) || fire;
    trig         = pulse_set || (pulse_count != '0);
    if (pulse_set) begin
      pulse_count_next = PULSE_LOAD;
    end else if (pulse_count != '0) begin
      pulse_count_next = PULSE_W'(pulse_count - 1'b1);
    end else begin
      pulse_count_next = '0;
    end
  end

  // fifo request for this tick
  always_comb begin
    fifo_req.valid     = advance;
    fifo_req.push      = push;
    fifo_req.clear     = block_enable && is_write && oneshot && s1_wval;
    fifo_req.read      = block_enable && is_read;
    fifo_req.push_data = width_cm;
  end

  urc_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .req     (fifo_req),
    .stat    (fifo_stat),
    .rd_data (fifo_rd)
  );

  // status and read result
  always_comb begin
    read_valid = block_enable && is_read && !fifo_stat.empty;
    if (!cmd_any) begin
      status = STAT_OK;
    end else if (!block_enable) begin
      status = STAT_DISABLED;
    end else if (is_read && fifo_stat.empty) begin
      status = STAT_EMPTY;
    end else begin
      status = STAT_OK;
    end
  end

  // ranging state update
  always_ff @(posedge clk) begin
    if (rst) begin
      echo_prev    <= 1'b0;
      width_count  <= '0;
      width_rem    <= '0;
      width_cm     <= '0;
      pulse_count  <= '0;
      period_count <= '0;
      running      <= 1'b0;
    end else if (advance) begin
      echo_prev    <= s1_echo;
      width_count  <= width_count_next;
      width_rem    <= width_rem_next;
      width_cm     <= width_cm_next;
      pulse_count  <= pulse_count_next;
      period_count <= period_count_next;
      running      <= running_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      r_trig   <= trig;
      r_valid  <= read_valid;
      r_status <= status;
      r_fill   <= fifo_stat.fill_count;
      r_active <= running_next;
    end
  end

  // output packing
  assign m_tdata = {1'b0, r_active, r_fill, r_status,
                    (r_valid ? fifo_rd : {DIST_W{1'b0}}), r_trig};
  assign m_tuser = r_valid;

endmodule

>>> rtl/urc_fifo.sv
// distance fifo that drops its oldest entry when full, with registered read
module urc_fifo #(
  parameter int DEPTH = 5
) (
  input  logic                             clk,
  input  logic                             rst,
  input  urc_pkg::fifo_req_t               req,
  output urc_pkg::fifo_stat_t              stat,
  output logic [urc_pkg::DIST_W-1:0]       rd_data
);
  import urc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  logic [DIST_W-1:0] mem [DEPTH];
  logic [AW-1:0]     wr_idx, wr_idx_next;
  logic [AW-1:0]     rd_idx, rd_idx_next;
  logic [CW-1:0]     cnt, cnt_next;
  logic [AW-1:0]     wr_after_push, rd_after_push;
  logic [CW-1:0]     cnt_after_push;
  logic              full, pop;
  logic [DIST_W-1:0] mem_q;
  logic [DIST_W-1:0] byp_data;
  logic              byp_sel;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i);
    return (i == LAST_SLOT) ? '0 : AW'(i + 1'b1);
  endfunction

  // push first, then clear or pop
  always_comb begin
    full           = (cnt == FULL_CNT);
    wr_after_push  = req.push ? next_slot(wr_idx) : wr_idx;
    rd_after_push  = (req.push && full) ? next_slot(rd_idx) : rd_idx;
    cnt_after_push = (req.push && !full) ? CW'(cnt + 1'b1) : cnt;
    pop            = req.read && (cnt_after_push != '0);
    wr_idx_next    = wr_after_push;
    rd_idx_next    = rd_after_push;
    cnt_next       = cnt_after_push;
    if (req.clear) begin
      wr_idx_next = '0;
      rd_idx_next = '0;
      cnt_next    = '0;
    end else if (pop) begin
      rd_idx_next = next_slot(rd_after_push);
      cnt_next    = CW'(cnt_after_push - 1'b1);
    end
  end

  assign stat.empty      = (cnt_after_push == '0);
  assign stat.fill_count = 3'(cnt_next);

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      cnt    <= '0;
    end else if (req.valid) begin
      wr_idx <= wr_idx_next;
      rd_idx <= rd_idx_next;
      cnt    <= cnt_next;
    end
  end

  // storage write
  always_ff @(posedge clk) begin
    if (req.valid && req.push) begin
      mem[wr_idx] <= req.push_data;
    end
  end

  // registered read, forwarding an entry written in the same tick
  always_ff @(posedge clk) begin
    if (req.valid) begin
      mem_q    <= mem[rd_after_push];
      byp_data <= req.push_data;
      byp_sel  <= req.push && (rd_after_push == wr_idx);
    end
  end

  assign rd_data = byp_sel ? byp_data : mem_q;

endmodule

>>> sim/urc_result_checker.sv
// result checker for the ranging controller: predicts every tick and compares results
module urc_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  input  logic [0:0]  m_tuser,
  output int          mismatches,
  output int          outstanding,
  output int          compared,
  output int          popped,
  output int          peak_distance,
  output int          peak_fill
);
  timeunit 1ns;
  timeprecision 1ps;
  import urc_pkg::*;

  localparam int          DEPTH        = 5;
  localparam logic [31:0] TICKS_PER_CM = 32'd58 * 32'd400;
  localparam logic [11:0] PULSE_TICKS  = 12'd4000;

  typedef struct {
    bit          trig;
    bit          valid;
    logic [15:0] dist_cm;
    status_t     status;
    logic [2:0]  fill;
    bit          active;
  } range_result_t;

  // configuration as last written
  bit          cfg_mode;
  logic [4:0]  cfg_rate;
  bit          cfg_enable;

  // predicted state of the block
  bit          echo_last;
  logic [31:0] echo_ticks;
  logic [11:0] pulse_left;
  logic [28:0] period_left;
  bit          is_running;
  logic [15:0] ring [DEPTH];
  int          wr_ptr;
  int          rd_ptr;
  logic [2:0]  fill;

  range_result_t predicted_results[$];

  function automatic int next_slot(input int i);
    return (i + 1 >= DEPTH) ? 0 : i + 1;
  endfunction

  // trigger period in ticks, rate clamped to 1..16 hz
  function automatic logic [28:0] trigger_period();
    int f;
    f = cfg_rate;
    if (f < 1) f = 1;
    if (f > 16) f = 16;
    return 29'((1000 / f) * 1000 * 400);
  endfunction

  // store a distance, dropping the oldest entry when full
  task automatic store_distance(input logic [15:0] d);
    ring[wr_ptr] = d;
    wr_ptr = next_slot(wr_ptr);
    if (fill >= DEPTH) rd_ptr = next_slot(rd_ptr);
    else fill++;
  endtask

  // one timestamp tick: echo capture, command, periodic trigger, trigger output
  task automatic advance_tick(input cmd_t cmd, input bit echo, input bit wval,
                              output range_result_t r);
    logic [31:0] cm;
    r.trig = 0;
    r.valid = 0;
    r.dist_cm = '0;
    r.status = STAT_OK;
    if (!cfg_mode) is_running = 0;
    // echo timing
    if (echo) begin
      if (!echo_last) echo_ticks = 32'd1;
      else if (echo_ticks != '1) echo_ticks++;
    end else if (echo_last) begin
      cm = echo_ticks / TICKS_PER_CM;
      store_distance((cm > 32'd65535) ? 16'hFFFF : cm[15:0]);
    end
    echo_last = echo;
    // command
    if (cmd == CMD_WRITE || cmd == CMD_READ) begin
      if (!cfg_enable) begin
        r.status = STAT_DISABLED;
      end else if (cmd == CMD_WRITE) begin
        if (!cfg_mode) begin
          if (wval) begin
            wr_ptr = 0;
            rd_ptr = 0;
            fill = 0;
          end
          pulse_left = PULSE_TICKS;
        end else if (wval) begin
          is_running = 1;
          period_left = '0;
        end else begin
          is_running = 0;
        end
      end else begin
        if (!cfg_mode) pulse_left = PULSE_TICKS;
        if (fill == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.dist_cm = ring[rd_ptr];
          r.valid = 1;
          rd_ptr = next_slot(rd_ptr);
          fill--;
        end
      end
    end
    // periodic trigger while running
    if (is_running) begin
      if (period_left == 0) begin
        pulse_left = PULSE_TICKS;
        period_left = trigger_period() - 29'd1;
      end else begin
        period_left--;
      end
    end
    r.trig = (pulse_left != 0);
    if (pulse_left != 0) pulse_left--;
    r.fill = fill;
    r.active = is_running;
  endtask

  task automatic report_mismatch(input string field, input int got, input int want);
    if (mismatches < 30)
      $display("%0t ns: result %0d field %s got %0d expected %0d",
               $time, compared, field, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    range_result_t want, got;
    if (rst) begin
      cfg_mode = 0;
      cfg_rate = 5'd16;
      cfg_enable = 1;
      echo_last = 0;
      echo_ticks = '0;
      pulse_left = '0;
      period_left = '0;
      is_running = 0;
      wr_ptr = 0;
      rd_ptr = 0;
      fill = '0;
      predicted_results.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_RANGE_MODE:   cfg_mode = cfg_data[0];
          CFG_TRIGGER_RATE: cfg_rate = cfg_data;
          CFG_BLOCK_ENABLE: cfg_enable = cfg_data[0];
          default: ;
        endcase
      end
      // input transaction
      if (s_tvalid && s_tready) begin
        advance_tick(cmd_t'(s_tuser), s_tdata[0], s_tdata[1], want);
        predicted_results.push_back(want);
      end
      // result transaction
      if (m_tvalid && m_tready) begin
        got.trig = m_tdata[0];
        got.dist_cm = m_tdata[16:1];
        got.status = status_t'(m_tdata[18:17]);
        got.fill = m_tdata[21:19];
        got.active = m_tdata[22];
        got.valid = m_tuser[0];
        if (predicted_results.size() == 0) begin
          report_mismatch("unexpected transaction", 1, 0);
        end else begin
          want = predicted_results.pop_front();
          if (got.trig != want.trig) report_mismatch("trigger_level", got.trig, want.trig);
          if (got.valid != want.valid) report_mismatch("read_valid", got.valid, want.valid);
          if (got.dist_cm != want.dist_cm)
            report_mismatch("distance_cm", got.dist_cm, want.dist_cm);
          if (got.status != want.status) report_mismatch("status", got.status, want.status);
          if (got.fill != want.fill) report_mismatch("fill_count", got.fill, want.fill);
          if (got.active != want.active)
            report_mismatch("ranging_active", got.active, want.active);
          if (want.valid) begin
            popped++;
            if (want.dist_cm > peak_distance) peak_distance = want.dist_cm;
          end
          if (want.fill > peak_fill) peak_fill = want.fill;
          compared++;
        end
      end
    end
    outstanding = predicted_results.size();
  end

  initial begin
    mismatches = 0;
    outstanding = 0;
    compared = 0;
    popped = 0;
    peak_distance = 0;
    peak_fill = 0;
  end

endmodule

>>> sim/ultrasonic_ranging_controller_top_test.sv
// stimulus and verdict for the ultrasonic ranging controller
module ultrasonic_ranging_controller_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import urc_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [4:0]  cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // echo_level, write_value, zero fill
  logic [1:0]  s_tuser;   // cmd
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // trigger_level, distance_cm, status, fill_count, ranging_active
  logic [0:0]  m_tuser;   // read_valid

  int mismatches, outstanding, compared, popped, peak_distance, peak_fill;

  // sender pacing and echo waveform state
  int burst_left;
  bit steady_send;
  bit stall_request;
  bit cur_mode;
  bit echo_now;
  int echo_run;
  int ticks_sent;
  int settings_used;
  int cycles;

  always #5ns clk = ~clk;

  ultrasonic_ranging_controller_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  urc_result_checker result_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .compared      (compared),
    .popped        (popped),
    .peak_distance (peak_distance),
    .peak_fill     (peak_fill)
  );

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycles, outstanding);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random ready patterns, plus a long hold-off on request
  initial begin
    int mode_left;
    int hold_left;
    int ready_mode;
    m_tready = 1'b0;
    mode_left = 0;
    hold_left = 0;
    ready_mode = 0;
    forever begin
      @(posedge clk);
      if (stall_request) begin
        hold_left = 400;
        stall_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          ready_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 300);
        end
        mode_left--;
        case (ready_mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 9) != 0);
          default: m_tready <= ((mode_left % 5) < 3);
        endcase
      end
    end
  end

  // offer one tick and wait for its transaction, idling between bursts
  task automatic send_tick(input cmd_t cmd, input bit echo, input bit wval);
    int gap;
    gap = 0;
    if (!steady_send && burst_left == 0) begin
      if ($urandom_range(0, 4) == 0) begin
        burst_left = 200;
      end else begin
        burst_left = $urandom_range(1, 40);
        gap = $urandom_range(0, 6);
      end
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= {6'b0, wval, echo};
    s_tuser <= cmd;
    do @(posedge clk); while (!s_tready);
    ticks_sent++;
  endtask

  // stop offering and let every result come back
  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  // write all three registers on consecutive edges while idle
  task automatic apply_setting(input bit mode, input logic [4:0] rate, input bit en);
    cfg_we <= 1'b1;
    cfg_index <= CFG_RANGE_MODE;
    cfg_data <= {4'b0, mode};
    @(posedge clk);
    cfg_index <= CFG_TRIGGER_RATE;
    cfg_data <= rate;
    @(posedge clk);
    cfg_index <= CFG_BLOCK_ENABLE;
    cfg_data <= {4'b0, en};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_mode = mode;
    settings_used++;
  endtask

  // echo held high for a given number of ticks, then one falling tick
  task automatic long_echo(input int width);
    for (int i = 0; i < width; i++)
      send_tick(($urandom_range(0, 63) == 0) ? CMD_UNUSED : CMD_TICK, 1'b1,
                1'($urandom_range(0, 1)));
    send_tick(CMD_TICK, 1'b0, 1'b0);
  endtask

  // echo pulses of random width with commands mixed in
  task automatic random_ticks(input int count, input int read_pct, input int max_high,
                              input int max_low);
    cmd_t cmd;
    int pick;
    bit wval;
    for (int i = 0; i < count; i++) begin
      if (echo_run == 0) begin
        echo_now = !echo_now;
        echo_run = echo_now ? $urandom_range(1, max_high) : $urandom_range(1, max_low);
      end
      echo_run--;
      pick = $urandom_range(0, 99);
      if (pick < read_pct) cmd = CMD_READ;
      else if (pick < read_pct + 12) cmd = CMD_WRITE;
      else if (pick < read_pct + 20) cmd = CMD_UNUSED;
      else cmd = CMD_TICK;
      wval = cur_mode ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 4) == 0);
      if (cmd == CMD_TICK || cmd == CMD_UNUSED) wval = 1'($urandom_range(0, 1));
      send_tick(cmd, echo_now, wval);
    end
  endtask

  // main stimulus
  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_RANGE_MODE;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = CMD_TICK;
    burst_left = 0;
    steady_send = 0;
    stall_request = 0;
    cur_mode = 0;
    echo_now = 0;
    echo_run = 0;
    ticks_sent = 0;
    settings_used = 0;
    cycles = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // one-shot: empty read, writes, unused command, overflow, capture with read and clear
    apply_setting(1'b0, 5'd16, 1'b1);
    send_tick(CMD_TICK, 1'b0, 1'b0);
    send_tick(CMD_READ, 1'b0, 1'b0);
    send_tick(CMD_WRITE, 1'b0, 1'b0);
    send_tick(CMD_WRITE, 1'b0, 1'b1);
    send_tick(CMD_UNUSED, 1'b0, 1'b1);
    for (int i = 0; i < 6; i++) begin
      send_tick(CMD_TICK, 1'b1, 1'b0);
      send_tick(CMD_TICK, 1'b0, 1'b1);
    end
    send_tick(CMD_TICK, 1'b1, 1'b0);
    send_tick(CMD_READ, 1'b0, 1'b0);
    send_tick(CMD_TICK, 1'b1, 1'b0);
    send_tick(CMD_WRITE, 1'b0, 1'b1);
    drain();

    // continuous: start, restart while running, stop, stop while stopped, start again
    apply_setting(1'b1, 5'd1, 1'b1);
    send_tick(CMD_WRITE, 1'b0, 1'b1);
    send_tick(CMD_WRITE, 1'b0, 1'b1);
    send_tick(CMD_WRITE, 1'b0, 1'b0);
    send_tick(CMD_WRITE, 1'b0, 1'b0);
    send_tick(CMD_WRITE, 1'b0, 1'b1);
    drain();

    // leave continuous mode while running, disabled, rate below range
    apply_setting(1'b0, 5'd0, 1'b0);
    send_tick(CMD_READ, 1'b0, 1'b0);
    send_tick(CMD_WRITE, 1'b0, 1'b1);
    drain();

    // long echoes just below, at and above whole centimetres
    apply_setting(1'b0, 5'd8, 1'b1);
    send_tick(CMD_WRITE, 1'b0, 1'b1);
    long_echo(23199);
    long_echo(23200);
    long_echo(46400 + $urandom_range(0, 23199));
    repeat (4) send_tick(CMD_READ, 1'b0, 1'b0);
    drain();

    // random phases over several settings, extremes first
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: apply_setting(1'b0, 5'd16, 1'b1);
        1: apply_setting(1'b1, 5'd1, 1'b1);
        2: apply_setting(1'b1, 5'd16, 1'b1);
        3: apply_setting(1'b0, 5'd0, 1'b0);
        4: apply_setting(1'b1, 5'd31, 1'b0);
        default: apply_setting(1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
                               ($urandom_range(0, 4) != 0));
      endcase
      if (p == 0) begin
        // receiver holds off while the sender keeps offering
        steady_send = 1;
        stall_request = 1;
        random_ticks(60, 5, 8, 8);
        steady_send = 0;
        random_ticks(140, 5, 8, 8);
      end else begin
        random_ticks(200, $urandom_range(3, 30), $urandom_range(1, 30),
                     $urandom_range(1, 12));
      end
      drain();
    end

    $display("covered %0d ticks under %0d register settings, %0d results compared",
             ticks_sent, settings_used, compared);
    $display("popped %0d distances up to %0d cm, fifo peak %0d entries",
             popped, peak_distance, peak_fill);
    if (mismatches == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
